### src/mhtq_pkg.sv
// Shared types, codes and compare helpers for the min-heap timer queue.
// No dependencies; used by every module of the block but the RAM, and by its checker.
package mhtq_pkg;

   // most expirations reported per tick word
   localparam int unsigned MaxPops = 16;
   localparam int unsigned PopW    = $clog2(MaxPops + 1);

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_TICK   = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_ACCEPT  = 2'd0,
      KIND_REJECT  = 2'd1,
      KIND_EXPIRED = 2'd2
   } kind_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  timer_id;
      logic [15:0] delay;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] expired_id;
      logic       last;
   } rsp_type;

   // one heap slot as held in the RAM
   typedef struct packed {
      logic [7:0]  id;
      logic [31:0] expiry;
   } entry_type;

   // read address source
   typedef enum logic [2:0] {
      ADDR_PARENT = 3'd0,
      ADDR_ROOT   = 3'd1,
      ADDR_LAST   = 3'd2,
      ADDR_LEFT   = 3'd3,
      ADDR_RIGHT  = 3'd4
   } addr_sel_type;

   // write data source
   typedef enum logic [1:0] {
      WR_CUR   = 2'd0,
      WR_RD    = 2'd1,
      WR_CHILD = 2'd2
   } wr_sel_type;

   // next value of the slot index
   typedef enum logic [2:0] {
      IDX_KEEP   = 3'd0,
      IDX_COUNT  = 3'd1,
      IDX_PARENT = 3'd2,
      IDX_CHILD  = 3'd3,
      IDX_ZERO   = 3'd4
   } idx_sel_type;

   typedef struct packed {
      logic         ld_insert;
      logic         ld_tick;
      logic         ld_cur_rd;
      logic         ld_left;
      logic         rd_en;
      addr_sel_type rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      idx_sel_type  idx_sel;
      logic         use_best;
      logic         count_inc;
      logic         count_dec;
      logic         pop;
      logic         emit;
      kind_type     emit_kind;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic count_zero;
      logic idx_zero;
      logic pops_done;
      logic root_due;
      logic pend_valid;
      logic more_left;
      logic left_in;
      logic right_in;
      logic child_earlier;
      logic new_earlier;
   } status_type;

   // a strictly before b, modulo 2^32
   function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   // expiry e not after time t
   function automatic logic is_due(input logic [31:0] e, input logic [31:0] t);
      logic [31:0] d;
      d = e - t;
      return (d == 32'd0) || d[31];
   endfunction

endpackage

### src/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: controller plus datapath.
// Depends on mhtq_pkg, mhtq_ctrl, mhtq_datapath (and mhtq_ram below it).
//
// Usage:
//   Request channel: a word on req_data is taken at a clock edge with start
//   high and busy low. action insert stores timer_id with expiry now+delay;
//   action tick advances the time by one and pops the due timers (at most 16).
//   Result channel: each result shows on rsp_data for one cycle with
//   rsp_valid high; the receiver cannot hold results off. An insert gives one
//   result (accepted or rejected when full); a tick gives one result per
//   expired timer, at most 16, with last set on the final one, or none.
// Sequence:
//   rejected insert: the result alone; accepted insert: parents move down
//   until the new entry fits or reaches the root. The result shows as busy
//   drops. tick: each pop moves the last entry to the root and sifts it
//   down before the next root check; a pop that empties the heap skips it.
//   Items are processed one at a time; busy is high throughout.
// Reset: the heap is empty and the time is zero; heap contents are not
//   cleared, so no clearing pass is needed and the block is ready at once.
module min_heap_timer_queue
   import mhtq_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   mhtq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   mhtq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/mhtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mhtq_datapath.sv
// Datapath of the timer queue: heap RAM, time, count, index and result registers.
// Depends on mhtq_pkg and mhtq_ram.
module mhtq_datapath
   import mhtq_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int unsigned IdxW = $clog2(CAPACITY);
   localparam int unsigned CntW = $clog2(CAPACITY + 1);
   localparam int unsigned WidW = CntW + 1;

   logic [CntW-1:0]  count_ff, count_in;
   logic [31:0]      now_ff, now_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   entry_type        cur_ff, cur_in;
   entry_type        left_ff;
   logic [PopW-1:0]  pops_ff, pops_in;
   logic [7:0]       pend_id_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   entry_type        rd_entry;
   logic [$bits(entry_type)-1:0] rd_raw;
   entry_type        wr_entry;
   logic [IdxW-1:0]  rd_addr;
   logic [IdxW-1:0]  parent_idx;
   logic [WidW-1:0]  left_w, right_w;
   entry_type        child;
   logic [IdxW-1:0]  child_idx;
   logic             right_better;

   // heap geometry
   assign parent_idx = (idx_ff - IdxW'(1)) >> 1;
   assign left_w     = {CntW'(idx_ff), 1'b1};
   assign right_w    = left_w + WidW'(1);

   assign rd_entry = entry_type'(rd_raw);

   // smaller child, left on a tie
   assign right_better = earlier(rd_entry.expiry, left_ff.expiry);
   always_comb begin
      if (cmd.use_best && right_better) begin
         child     = rd_entry;
         child_idx = right_w[IdxW-1:0];
      end else if (cmd.use_best) begin
         child     = left_ff;
         child_idx = left_w[IdxW-1:0];
      end else begin
         child     = rd_entry;
         child_idx = left_w[IdxW-1:0];
      end
   end

   // read address
   always_comb begin
      case (cmd.rd_sel)
         ADDR_PARENT: rd_addr = parent_idx;
         ADDR_ROOT:   rd_addr = '0;
         ADDR_LAST:   rd_addr = IdxW'(count_ff - CntW'(1));
         ADDR_LEFT:   rd_addr = left_w[IdxW-1:0];
         ADDR_RIGHT:  rd_addr = right_w[IdxW-1:0];
         default:     rd_addr = '0;
      endcase
   end

   // write data
   always_comb begin
      case (cmd.wr_sel)
         WR_CUR:   wr_entry = cur_ff;
         WR_RD:    wr_entry = rd_entry;
         WR_CHILD: wr_entry = child;
         default:  wr_entry = cur_ff;
      endcase
   end

   mhtq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // next state of the control registers
   always_comb begin
      count_in      = count_ff;
      now_in        = now_ff;
      pops_in       = pops_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CntW'(1);
      end
      if (cmd.ld_tick) begin
         now_in        = now_ff + 32'd1;
         pops_in       = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.pop) begin
         pops_in       = pops_ff + PopW'(1);
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      case (cmd.idx_sel)
         IDX_KEEP:   idx_in = idx_ff;
         IDX_COUNT:  idx_in = IdxW'(count_ff);
         IDX_PARENT: idx_in = parent_idx;
         IDX_CHILD:  idx_in = child_idx;
         IDX_ZERO:   idx_in = '0;
         default:    idx_in = idx_ff;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.ld_insert) begin
         cur_in.id     = req_data.timer_id;
         cur_in.expiry = now_ff + {16'd0, req_data.delay};
      end else if (cmd.ld_cur_rd) begin
         cur_in = rd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         now_ff        <= '0;
         pops_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         now_ff        <= now_in;
         pops_ff       <= pops_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      if (cmd.ld_left) begin
         left_ff <= rd_entry;
      end
      if (cmd.pop) begin
         pend_id_ff <= rd_entry.id;
      end
      if (cmd.emit) begin
         rsp_data_ff.kind       <= cmd.emit_kind;
         rsp_data_ff.expired_id <= (cmd.emit_kind == KIND_EXPIRED) ? pend_id_ff : 8'd0;
         rsp_data_ff.last       <= cmd.emit_last;
      end
   end

   // status back to the controller
   assign status.full          = (count_ff == CntW'(CAPACITY));
   assign status.count_zero    = (count_ff == '0);
   assign status.idx_zero      = (idx_ff == '0);
   assign status.pops_done     = (pops_ff == PopW'(MaxPops));
   assign status.root_due      = is_due(rd_entry.expiry, now_ff);
   assign status.pend_valid    = pend_valid_ff;
   assign status.more_left     = (count_ff != CntW'(1));
   assign status.left_in       = (left_w < WidW'(count_ff));
   assign status.right_in      = (right_w < WidW'(count_ff));
   assign status.child_earlier = earlier(child.expiry, cur_ff.expiry);
   assign status.new_earlier   = earlier(cur_ff.expiry, rd_entry.expiry);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/mhtq_ctrl.sv
// Controller of the timer queue: sequences sift-up, pops and sift-down.
// Depends on mhtq_pkg.
module mhtq_ctrl
   import mhtq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  action_type action,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_REJ      = 10'b00_0000_0010,
      S_UP       = 10'b00_0000_0100,
      S_UP_CMP   = 10'b00_0000_1000,
      S_POP_CHK  = 10'b00_0001_0000,
      S_POP_TEST = 10'b00_0010_0000,
      S_SD_LOAD  = 10'b00_0100_0000,
      S_SD_L     = 10'b00_1000_0000,
      S_SD_R     = 10'b01_0000_0000,
      S_SD_CMP   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = ADDR_ROOT;
      cmd.wr_sel    = WR_CUR;
      cmd.idx_sel   = IDX_KEEP;
      cmd.emit_kind = KIND_ACCEPT;
      case (state_ff)
         S_IDLE: begin
            if (start && (action == ACT_TICK)) begin
               cmd.ld_tick = 1'b1;
               state_in    = S_POP_CHK;
            end else if (start && status.full) begin
               state_in = S_REJ;
            end else if (start) begin
               cmd.ld_insert = 1'b1;
               cmd.idx_sel   = IDX_COUNT;
               state_in      = S_UP;
            end
         end
         S_REJ: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_REJECT;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         // sift-up: pull parents down until the new entry fits
         S_UP: begin
            if (status.idx_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.new_earlier) begin
               cmd.wr_sel  = WR_RD;
               cmd.idx_sel = IDX_PARENT;
               state_in    = S_UP;
            end else begin
               cmd.count_inc = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         // pop loop: fetch root, or close out the tick
         S_POP_CHK: begin
            if (status.count_zero || status.pops_done) begin
               cmd.emit      = status.pend_valid;
               cmd.emit_kind = KIND_EXPIRED;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_POP_TEST;
            end
         end
         // the held expiry goes out once we know whether another follows
         S_POP_TEST: begin
            cmd.emit      = status.pend_valid;
            cmd.emit_kind = KIND_EXPIRED;
            if (status.root_due) begin
               cmd.pop       = 1'b1;
               cmd.count_dec = 1'b1;
               if (status.more_left) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = ADDR_LAST;
                  state_in   = S_SD_LOAD;
               end else begin
                  state_in = S_POP_CHK;
               end
            end else begin
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         // sift-down of the last entry from the root
         S_SD_LOAD: begin
            cmd.ld_cur_rd = 1'b1;
            cmd.idx_sel   = IDX_ZERO;
            state_in      = S_SD_L;
         end
         S_SD_L: begin
            if (status.left_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_LEFT;
               state_in   = S_SD_R;
            end else begin
               cmd.wr_en = 1'b1;
               state_in  = S_POP_CHK;
            end
         end
         S_SD_R: begin
            cmd.ld_left = 1'b1;
            if (status.right_in) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_RIGHT;
               state_in   = S_SD_CMP;
            end else begin
               cmd.wr_en = 1'b1;
               if (status.child_earlier) begin
                  cmd.wr_sel  = WR_CHILD;
                  cmd.idx_sel = IDX_CHILD;
                  state_in    = S_SD_L;
               end else begin
                  state_in = S_POP_CHK;
               end
            end
         end
         S_SD_CMP: begin
            cmd.use_best = 1'b1;
            cmd.wr_en    = 1'b1;
            if (status.child_earlier) begin
               cmd.wr_sel  = WR_CHILD;
               cmd.idx_sel = IDX_CHILD;
               state_in    = S_SD_L;
            end else begin
               state_in = S_POP_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### src/mhtq_checker.sv
// Port-level checks on the timer queue, attached to the top level by bind.
// Depends on mhtq_pkg and min_heap_timer_queue.
module mhtq_checker
   import mhtq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted word always raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // insert results are single and final
   a_insert_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_EXPIRED) |-> rsp_data.last)
      else $error("insert result without last");

   // insert results carry no timer id
   a_insert_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_EXPIRED) |-> rsp_data.expired_id == 8'd0)
      else $error("insert result with non-zero id");

   // a final result is never directly followed by another
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result right after a final result");

   // reset leaves the block idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind min_heap_timer_queue mhtq_checker u_mhtq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### bench/tb_top.sv
// Self-checking bench for the min-heap timer queue: directed script, then random bursts.
// Holds its own heap model of the queue for the expected expirations.
// Depends on mhtq_pkg and min_heap_timer_queue.
module tb_top
   import mhtq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Cap       = 16;
   localparam int          QuietMax  = 5000;  // cycles with no word moving
   localparam int          TailWait  = 400;   // worst tick: 16 pops with sift-down
   localparam int          PhaseLen  = 167;

   // how a script row is checked
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_ONE
   } row_mode_type;

   typedef struct {
      req_type      word;
      row_mode_type mode;
      kind_type     want;
   } script_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // heap model state
   logic [7:0]  heap_id  [Cap];
   logic [31:0] heap_exp [Cap];
   int unsigned live_count;
   logic [31:0] now_ticks;

   rsp_type        step_results[$];
   rsp_type        pending_results[$];
   script_row_type script[$];
   int             idle_pct[3] = '{0, 57, 11};
   int             errors;
   int             quiet;

   min_heap_timer_queue #(
      .CAPACITY(Cap)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // a strictly ahead of b on the wrapping time line
   function automatic bit precedes(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

   // expiry no later than the current time
   function automatic bit is_ripe(input logic [31:0] e);
      logic [31:0] d;
      d = e - now_ticks;
      return (d == 32'd0) || d[31];
   endfunction

   // advance the heap model by one word; its results land in step_results
   task automatic model_word(input req_type w);
      int unsigned slot, par, lc, rc, pick, pops;
      logic [31:0] ex;
      logic [7:0]  tid;
      bit          moving;
      rsp_type     r;
      step_results.delete();
      if (w.action == ACT_INSERT) begin
         r.expired_id = 8'd0;
         r.last       = 1'b1;
         if (live_count >= Cap) begin
            r.kind = KIND_REJECT;
         end else begin
            ex     = now_ticks + 32'(w.delay);
            slot   = live_count;
            moving = 1'b1;
            // sift up on strictly earlier expiry
            while (moving && slot > 0) begin
               par = (slot - 1) / 2;
               if (precedes(ex, heap_exp[par])) begin
                  heap_id[slot]  = heap_id[par];
                  heap_exp[slot] = heap_exp[par];
                  slot = par;
               end else begin
                  moving = 1'b0;
               end
            end
            heap_id[slot]  = w.timer_id;
            heap_exp[slot] = ex;
            live_count++;
            r.kind = KIND_ACCEPT;
         end
         step_results.push_back(r);
      end else begin
         now_ticks = now_ticks + 32'd1;
         pops = 0;
         while (live_count > 0 && pops < MaxPops && is_ripe(heap_exp[0])) begin
            r.kind       = KIND_EXPIRED;
            r.expired_id = heap_id[0];
            r.last       = 1'b0;
            step_results.push_back(r);
            pops++;
            live_count--;
            if (live_count > 0) begin
               // last entry to the root, then sift down, left child on a tie
               tid    = heap_id[live_count];
               ex     = heap_exp[live_count];
               slot   = 0;
               moving = 1'b1;
               while (moving) begin
                  lc = 2 * slot + 1;
                  rc = lc + 1;
                  if (lc >= live_count) begin
                     moving = 1'b0;
                  end else begin
                     pick = lc;
                     if (rc < live_count && precedes(heap_exp[rc], heap_exp[lc]))
                        pick = rc;
                     if (precedes(heap_exp[pick], ex)) begin
                        heap_id[slot]  = heap_id[pick];
                        heap_exp[slot] = heap_exp[pick];
                        slot = pick;
                     end else begin
                        moving = 1'b0;
                     end
                  end
               end
               heap_id[slot]  = tid;
               heap_exp[slot] = ex;
            end
         end
         if (pops > 0) begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
         end
      end
   endtask

   function automatic void add_row(input action_type act, input logic [7:0] id,
                                   input logic [15:0] dly, input row_mode_type mode,
                                   input kind_type want);
      script_row_type s;
      s.word.action   = act;
      s.word.timer_id = id;
      s.word.delay    = dly;
      s.mode          = mode;
      s.want          = want;
      script.push_back(s);
   endfunction

   // offer one word, hold it until taken, then book its expected results
   task automatic drive_word(input req_type w, input int pct, input row_mode_type mode,
                             input kind_type want);
      rsp_type r;
      while ($urandom_range(99) < pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      model_word(w);
      case (mode)
         CHECK_MODEL: begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
         end
         CHECK_ONE: begin
            r.kind       = want;
            r.expired_id = 8'd0;
            r.last       = 1'b1;
            pending_results.push_back(r);
         end
         default: ;
      endcase
   endtask

   // sender holds off until every booked result has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic req_type rand_insert();
      req_type w;
      int      sel;
      sel        = $urandom_range(99);
      w.action   = ACT_INSERT;
      w.timer_id = 8'($urandom_range(255));
      if (sel < 70)
         w.delay = 16'($urandom_range(8));
      else if (sel < 98)
         w.delay = 16'($urandom_range(300));
      else
         w.delay = 16'($urandom_range(65535));
      return w;
   endfunction

   function automatic req_type rand_tick();
      req_type w;
      w.action   = ACT_TICK;
      w.timer_id = 8'($urandom_range(255));
      w.delay    = 16'($urandom_range(65535));
      return w;
   endfunction

   // result check and watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind %0d id %0d last %0d", $time,
                        rsp_data.kind, rsp_data.expired_id, rsp_data.last);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  errors++;
                  $display("%0t: kind expected %0d got %0d", $time, want.kind,
                           rsp_data.kind);
               end
               if (rsp_data.expired_id !== want.expired_id) begin
                  errors++;
                  $display("%0t: expired_id expected %0d got %0d", $time,
                           want.expired_id, rsp_data.expired_id);
               end
               if (rsp_data.last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %0d got %0d", $time, want.last,
                           rsp_data.last);
               end
            end
         end
         if (rsp_valid === 1'b1 || (start === 1'b1 && busy === 1'b0))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QuietMax) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int ph, sent, n_ins, n_tick, k;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      errors   = 0;
      quiet    = 0;
      live_count = 0;
      now_ticks  = 32'd0;

      // directed script
      add_row(ACT_TICK,   8'hFF, 16'hFFFF, CHECK_NONE,  KIND_ACCEPT);  // empty heap
      add_row(ACT_INSERT, 8'hFF, 16'hFFFF, CHECK_ONE,   KIND_ACCEPT);  // farthest delay
      add_row(ACT_INSERT, 8'h00, 16'h0000, CHECK_ONE,   KIND_ACCEPT);  // due at next tick
      add_row(ACT_TICK,   8'h00, 16'h0000, CHECK_MODEL, KIND_ACCEPT);
      add_row(ACT_TICK,   8'h00, 16'h0000, CHECK_NONE,  KIND_ACCEPT);  // nothing due
      // fill to capacity with ties and near expiries
      for (k = 0; k < 15; k++)
         add_row(ACT_INSERT, 8'(8'hA0 + k), 16'(k % 3), CHECK_ONE, KIND_ACCEPT);
      add_row(ACT_INSERT, 8'h5A, 16'h0003, CHECK_ONE,   KIND_REJECT);  // heap full
      add_row(ACT_TICK,   8'h00, 16'h0000, CHECK_MODEL, KIND_ACCEPT);  // burst of pops
      add_row(ACT_TICK,   8'h00, 16'h0000, CHECK_MODEL, KIND_ACCEPT);
      add_row(ACT_TICK,   8'h00, 16'h0000, CHECK_NONE,  KIND_ACCEPT);  // only far entry left

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) drive_word(script[i].word, 0, script[i].mode, script[i].want);
      wait_drained();

      // random bursts of inserts then ticks, with some mixed noise
      for (ph = 0; ph < 3; ph++) begin
         sent = 0;
         while (sent < PhaseLen) begin
            if ($urandom_range(7) == 0) begin
               n_ins = $urandom_range(1, 6);
               for (k = 0; k < n_ins; k++) begin
                  if ($urandom_range(1) == 0)
                     drive_word(rand_insert(), idle_pct[ph], CHECK_MODEL, KIND_ACCEPT);
                  else
                     drive_word(rand_tick(), idle_pct[ph], CHECK_MODEL, KIND_ACCEPT);
                  sent++;
               end
            end else begin
               n_ins  = $urandom_range(1, 18);
               n_tick = $urandom_range(1, 12);
               for (k = 0; k < n_ins; k++) begin
                  drive_word(rand_insert(), idle_pct[ph], CHECK_MODEL, KIND_ACCEPT);
                  sent++;
               end
               for (k = 0; k < n_tick; k++) begin
                  drive_word(rand_tick(), idle_pct[ph], CHECK_MODEL, KIND_ACCEPT);
                  sent++;
               end
            end
         end
         wait_drained();
      end

      repeat (TailWait) @(posedge clock);
      if (pending_results.size() != 0)
         $display("%0t: %0d expected results never arrived", $time,
                  pending_results.size());
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
